[hdl/atqs_pkg.sv]
// Shared constants, types and helpers of the affinity task queue scheduler.
package atqs_pkg;

	localparam int QD    = 64;
	localparam int QAW   = 6;
	localparam int CW    = 7;
	localparam int TAW   = 8;
	localparam int NT    = 256;
	localparam int CAW   = 8;
	localparam int NC    = 256;
	localparam int RW    = 4;
	localparam int DW    = 19;
	localparam int LIMW  = 7;

	localparam logic [LIMW-1:0] HIT_LIMIT_RST = 7'd10;
	localparam logic [1:0]      FULL_SCORE    = 2'd2;

	localparam logic [2:0] ACT_WRITE  = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_GET    = 3'd2;
	localparam logic [2:0] ACT_REWIND = 3'd3;
	localparam logic [2:0] ACT_WAIT   = 3'd4;
	localparam logic [2:0] ACT_TABOO  = 3'd5;

	localparam logic [1:0] KIND_SORT  = 2'd0;
	localparam logic [1:0] KIND_SELF  = 2'd1;
	localparam logic [1:0] KIND_PAIR  = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_WAIT_WR, S_SC_TOP, S_SC_DESC, S_SC_A, S_SC_B, S_SC_EVAL,
		S_LK_B, S_REL_A, S_REL_B, S_FIN, S_OWN_B, S_SH, S_SH_WR, S_SD, S_SD_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CAW-1:0] rd_addr;
		logic [CAW-1:0] wr_addr;
		logic           own_we;
		logic [RW-1:0]  own_wd;
		logic           tab_we;
		logic           tab_wd;
	} cs_req_t;

	function automatic logic [1:0] d_kind(input logic [DW-1:0] d);
		return d[1:0];
	endfunction

	function automatic logic [CAW-1:0] d_cell_a(input logic [DW-1:0] d);
		return d[9:2];
	endfunction

	function automatic logic [CAW-1:0] d_cell_b(input logic [DW-1:0] d);
		return d[17:10];
	endfunction

	function automatic logic d_wait(input logic [DW-1:0] d);
		return d[18];
	endfunction

endpackage

[hdl/affinity_task_queue_scheduler.sv]
// Affinity task queue scheduler: sequencer, order list and task table.
// One item at a time. Set wait reads the task table entry, then writes it back.
// Insert shifts each pending entry up by one, then writes the new entry.
// A get scans pending entries (one order list read and one task table read
// each; for a task that is not waiting also two cell store reads and, when a
// lock is taken, up to four taboo writes; all memories are synchronous with
// separate read and write addresses), then makes one or two owner writes and
// moves entries in the order list one at a time.
// The result waits in an output register, so the next item can be taken while
// it is held. After reset a pass over all 256 cells clears the owner and taboo
// stores; input is stalled until it ends.
module affinity_task_queue_scheduler import atqs_pkg::*; #(
	parameter logic [LIMW-1:0] HIT_LIMIT_INIT = HIT_LIMIT_RST
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [2:0]      action,
	input  logic [TAW-1:0]  task_index,
	input  logic [1:0]      task_kind,
	input  logic [CAW-1:0]  first_cell,
	input  logic [CAW-1:0]  second_cell,
	input  logic            flag_value,
	input  logic [RW-1:0]   runner_id,
	input  logic            keep_entry,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            found,
	output logic [TAW-1:0]  chosen_task,
	output logic            inserted,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [LIMW-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [TAW-1:0] order_mem [QD];
	logic           order_we;
	logic [QAW-1:0] order_wa, order_ra;
	logic [TAW-1:0] order_wd, order_rd_q;

	logic [DW-1:0]  desc_mem [NT];
	logic           desc_we;
	logic [TAW-1:0] desc_wa, desc_ra;
	logic [DW-1:0]  desc_wd, desc_rd_q;

	cs_req_t        cs;
	logic [RW-1:0]  owner_rd;
	logic           taboo_rd;
	logic           cells_clr;

	logic [CW-1:0]   np_q, ec_q, k_q, best_k_q, k_dec, k_inc;
	logic [LIMW-1:0] lim_q, hit_q;
	logic [TAW-1:0]  tix_q, tid_q, cur_tid_q, best_tid_q;
	logic [RW-1:0]   rid_q, own_a_q;
	logic            flag_q, keep_q, ins_op_q, have_q, tab_a_q, rel_en_q;
	logic [1:0]      bscore_q, score;
	logic [DW-1:0]   cur_d_q, best_d_q, rel_d_q;
	logic            res_found_q, res_ins_q;
	logic [TAW-1:0]  res_chosen_q;
	logic            out_valid_q, found_q, inserted_q;
	logic [TAW-1:0]  chosen_q;

	logic can_ins, scan_go, better, lock_ok, take, m_a, m_b, done_fire, in_fire;
	logic [1:0] kd;

	assign in_stall  = (state_q != S_IDLE) || cells_clr;
	assign in_fire   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign found       = found_q;
	assign chosen_task = chosen_q;
	assign inserted    = inserted_q;

	assign k_dec   = k_q - 1'b1;
	assign k_inc   = k_q + 1'b1;
	assign can_ins = (ec_q < CW'(QD)) && (np_q <= ec_q);
	assign scan_go = (k_q < ec_q) && (hit_q < lim_q);
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign kd  = d_kind(cur_d_q);
	assign m_a = (own_a_q == rid_q);
	assign m_b = (owner_rd == rid_q);

	always_comb begin
		case (kd)
			KIND_SORT, KIND_SELF: score = m_a ? FULL_SCORE : 2'd0;
			KIND_PAIR:            score = {1'b0, m_a} + {1'b0, m_b};
			default:              score = 2'd0;
		endcase
		case (kd)
			KIND_SORT, KIND_SELF: lock_ok = !tab_a_q;
			KIND_PAIR:            lock_ok = !tab_a_q && !taboo_rd &&
				(d_cell_a(cur_d_q) != d_cell_b(cur_d_q));
			default:              lock_ok = 1'b0;
		endcase
		better = !have_q || (score > bscore_q);
		take   = better && lock_ok;
	end

	atqs_cells u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (cs),
		.owner    (owner_rd),
		.taboo    (taboo_rd),
		.clearing (cells_clr)
	);

	always_ff @(posedge clk) begin
		if (order_we) order_mem[order_wa] <= order_wd;
		order_rd_q <= order_mem[order_ra];
		if (desc_we) desc_mem[desc_wa] <= desc_wd;
		desc_rd_q <= desc_mem[desc_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		order_we = 1'b0;
		order_wa = '0;
		order_wd = '0;
		order_ra = '0;
		desc_we  = 1'b0;
		desc_wa  = '0;
		desc_wd  = '0;
		desc_ra  = '0;
		cs       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (action)
						ACT_WRITE: begin
							desc_we = 1'b1;
							desc_wa = task_index;
							desc_wd = {flag_value, second_cell, first_cell, task_kind};
							state_d = S_DONE;
						end
						ACT_INSERT: state_d = can_ins ? S_SH : S_DONE;
						ACT_GET:    state_d = (np_q < ec_q) ? S_SC_TOP : S_DONE;
						ACT_WAIT: begin
							desc_ra = task_index;
							state_d = S_WAIT_WR;
						end
						ACT_TABOO: begin
							cs.wr_addr = first_cell;
							cs.tab_we  = 1'b1;
							cs.tab_wd  = flag_value;
							state_d    = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_WAIT_WR: begin
				desc_we = 1'b1;
				desc_wa = tix_q;
				desc_wd = {flag_q, desc_rd_q[DW-2:0]};
				state_d = S_DONE;
			end
			S_SC_TOP: begin
				if (scan_go) begin
					order_ra = k_q[QAW-1:0];
					state_d  = S_SC_DESC;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SC_DESC: begin
				desc_ra = order_rd_q;
				state_d = S_SC_A;
			end
			S_SC_A: begin
				if (d_wait(desc_rd_q)) begin
					state_d = S_SC_TOP;
				end else begin
					cs.rd_addr = d_cell_a(desc_rd_q);
					state_d    = S_SC_B;
				end
			end
			S_SC_B: begin
				cs.rd_addr = d_cell_b(cur_d_q);
				state_d    = S_SC_EVAL;
			end
			S_SC_EVAL: begin
				if (take) begin
					cs.wr_addr = d_cell_a(cur_d_q);
					cs.tab_we  = 1'b1;
					cs.tab_wd  = 1'b1;
					state_d    = S_LK_B;
				end else begin
					state_d = S_SC_TOP;
				end
			end
			S_LK_B: begin
				cs.wr_addr = d_cell_b(best_d_q);
				cs.tab_we  = (d_kind(best_d_q) == KIND_PAIR);
				cs.tab_wd  = 1'b1;
				state_d    = S_REL_A;
			end
			S_REL_A: begin
				cs.wr_addr = d_cell_a(rel_d_q);
				cs.tab_we  = rel_en_q;
				state_d    = S_REL_B;
			end
			S_REL_B: begin
				cs.wr_addr = d_cell_b(rel_d_q);
				cs.tab_we  = rel_en_q && (d_kind(rel_d_q) == KIND_PAIR);
				state_d    = (bscore_q == FULL_SCORE) ? S_FIN : S_SC_TOP;
			end
			S_FIN: begin
				if (have_q) begin
					cs.wr_addr = d_cell_a(best_d_q);
					cs.own_we  = 1'b1;
					cs.own_wd  = rid_q;
					state_d    = S_OWN_B;
				end else begin
					state_d = S_DONE;
				end
			end
			S_OWN_B: begin
				cs.wr_addr = d_cell_b(best_d_q);
				cs.own_we  = (d_kind(best_d_q) == KIND_PAIR);
				cs.own_wd  = rid_q;
				state_d    = keep_q ? S_SD : S_SH;
			end
			S_SH: begin
				if (k_q > np_q) begin
					order_ra = k_dec[QAW-1:0];
					state_d  = S_SH_WR;
				end else begin
					order_we = 1'b1;
					order_wa = np_q[QAW-1:0];
					order_wd = tid_q;
					state_d  = S_DONE;
				end
			end
			S_SH_WR: begin
				order_we = 1'b1;
				order_wa = k_q[QAW-1:0];
				order_wd = order_rd_q;
				state_d  = S_SH;
			end
			S_SD: begin
				if (k_q < ec_q) begin
					order_ra = k_inc[QAW-1:0];
					state_d  = S_SD_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SD_WR: begin
				order_we = 1'b1;
				order_wa = k_q[QAW-1:0];
				order_wd = order_rd_q;
				state_d  = S_SD;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q        <= '0;
			ec_q        <= '0;
			lim_q       <= HIT_LIMIT_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) lim_q <= cfg_data;
			if (in_fire && action == ACT_REWIND) np_q <= '0;
			if (state_q == S_SH && !(k_q > np_q)) begin
				np_q <= np_q + 1'b1;
				if (ins_op_q) ec_q <= ec_q + 1'b1;
			end
			if (state_q == S_OWN_B && keep_q) ec_q <= ec_q - 1'b1;
			out_valid_q <= done_fire | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					tix_q        <= task_index;
					tid_q        <= task_index;
					flag_q       <= flag_value;
					rid_q        <= runner_id;
					keep_q       <= keep_entry;
					ins_op_q     <= (action == ACT_INSERT);
					k_q          <= (action == ACT_INSERT) ? ec_q : np_q;
					hit_q        <= '0;
					have_q       <= 1'b0;
					res_found_q  <= 1'b0;
					res_chosen_q <= '0;
					res_ins_q    <= (action == ACT_INSERT) && can_ins;
				end
			end
			S_SC_TOP:  if (scan_go && have_q) hit_q <= hit_q + 1'b1;
			S_SC_DESC: cur_tid_q <= order_rd_q;
			S_SC_A: begin
				cur_d_q <= desc_rd_q;
				if (d_wait(desc_rd_q)) k_q <= k_inc;
			end
			S_SC_B: begin
				own_a_q <= owner_rd;
				tab_a_q <= taboo_rd;
			end
			S_SC_EVAL: begin
				if (take) begin
					rel_d_q    <= best_d_q;
					rel_en_q   <= have_q;
					best_d_q   <= cur_d_q;
					best_tid_q <= cur_tid_q;
					best_k_q   <= k_q;
					bscore_q   <= score;
					have_q     <= 1'b1;
				end else begin
					k_q <= k_inc;
				end
			end
			S_REL_B: if (bscore_q != FULL_SCORE) k_q <= k_inc;
			S_OWN_B: begin
				res_found_q  <= 1'b1;
				res_chosen_q <= best_tid_q;
				k_q          <= best_k_q;
				tid_q        <= best_tid_q;
			end
			S_SH_WR: k_q <= k_dec;
			S_SD_WR: k_q <= k_inc;
			default: ;
		endcase
		if (done_fire) begin
			found_q    <= res_found_q;
			chosen_q   <= res_chosen_q;
			inserted_q <= res_ins_q;
		end
	end

endmodule

[hdl/atqs_cells.sv]
// Cell owner and taboo stores, cleared by a pass over all cells after reset.
module atqs_cells import atqs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cs_req_t       req,
	output logic [RW-1:0] owner,
	output logic          taboo,
	output logic          clearing
);

	logic [RW-1:0]  own_mem [NC];
	logic           tab_mem [NC];
	logic [RW-1:0]  own_rd_q;
	logic           tab_rd_q;
	logic [CAW-1:0] clr_addr_q;
	logic           clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == CAW'(NC - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			own_mem[clr_addr_q] <= '0;
			tab_mem[clr_addr_q] <= 1'b0;
		end else begin
			if (req.own_we) own_mem[req.wr_addr] <= req.own_wd;
			if (req.tab_we) tab_mem[req.wr_addr] <= req.tab_wd;
		end
		own_rd_q <= own_mem[req.rd_addr];
		tab_rd_q <= tab_mem[req.rd_addr];
	end

	assign owner    = own_rd_q;
	assign taboo    = tab_rd_q;
	assign clearing = clr_busy_q;

endmodule
